### rtl/kwsc_pkg.sv
// Package for the keyword substitution cipher: letter indices, request codes,
// table write port type and the reset contents of both substitution tables.
// Depends on nothing; every other file imports it.
package kwsc_pkg;

    localparam int ALPHABET = 26;
    localparam int IDX_W    = 5;

    typedef logic [IDX_W-1:0] idx_t;

    // Request codes carried in the action field.
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_KEY    = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_DATA   = 2'd3
    } action_t;

    localparam logic [7:0] ASCII_UA  = 8'h41;
    localparam logic [7:0] ASCII_UZ  = 8'h5A;
    localparam logic [7:0] ASCII_LA  = 8'h61;
    localparam logic [7:0] ASCII_LZ  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    localparam idx_t LAST_IDX = idx_t'(ALPHABET - 1);
    localparam idx_t IDX_X    = idx_t'(23);
    localparam idx_t IDX_Y    = idx_t'(24);
    localparam idx_t IDX_Z    = idx_t'(25);

    // One write into a substitution table.
    typedef struct packed {
        logic we;
        idx_t addr;
        idx_t data;
    } ram_wr_t;

    // Read request issued by the key controller while it inverts the table.
    typedef struct packed {
        logic en;
        idx_t addr;
    } walk_rd_t;

    // Fill order Z X Y W V ... A; also the cipher table for an empty key.
    function automatic idx_t fill_letter(input idx_t pos);
        idx_t res;
        case (pos)
            idx_t'(0): res = IDX_Z;
            idx_t'(1): res = IDX_X;
            idx_t'(2): res = IDX_Y;
            default:   res = LAST_IDX - pos;
        endcase
        return res;
    endfunction

    // Inverse of the empty-key fill order.
    function automatic idx_t inverse_reset(input idx_t letter);
        idx_t res;
        case (letter)
            IDX_Z:   res = idx_t'(0);
            IDX_X:   res = idx_t'(1);
            IDX_Y:   res = idx_t'(2);
            default: res = LAST_IDX - letter;
        endcase
        return res;
    endfunction

endpackage

### rtl/kwsc_if.sv
// Valid/ready channel interfaces for the cipher: the request channel carries
// action and value, the result channel carries out_byte. Depends on kwsc_pkg.
interface kwsc_req_if
    import kwsc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface kwsc_res_if
    import kwsc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

### rtl/kwsc_table_ram.sv
// One 26-entry substitution table: synchronous RAM with one write and one
// registered read port, plus per-entry written flags. Depends on kwsc_pkg.
module kwsc_table_ram
    import kwsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ram_wr_t wr,
    input  idx_t    rd_addr,
    output idx_t    rd_data,
    output logic    rd_valid,
    output idx_t    rd_addr_q
);

    idx_t                mem_reg [ALPHABET];
    logic [ALPHABET-1:0] valid_reg;
    idx_t                rd_data_reg;
    idx_t                rd_addr_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem_reg[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // An entry never written since reset reads with its flag low, and the
    // user substitutes the reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_valid  = rd_valid_reg;
    assign rd_addr_q = rd_addr_reg;

endmodule

### rtl/kwsc_key_ctrl.sv
// Key controller: letter-used mask, key length, key entry, the fill walk and
// the inverse-table build. Drives the write ports of both tables. Uses kwsc_pkg.
module kwsc_key_ctrl
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_fire,
    input  logic [1:0] req_action,
    input  logic [7:0] req_value,
    input  idx_t       cipher_eff,
    output logic       busy,
    output ram_wr_t    cipher_wr,
    output ram_wr_t    inverse_wr,
    output walk_rd_t   walk_rd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_INVERT
    } state_t;

    state_t              state_reg, state_next;
    logic [ALPHABET-1:0] used_reg, used_next;
    idx_t                len_reg, len_next;
    idx_t                cnt_reg, cnt_next;

    logic [7:0] upper;
    logic [7:0] key_off;
    logic       key_letter;
    idx_t       place_idx;
    logic       place_try;
    logic       place_ok;

    always_comb
    begin
        upper = req_value;
        if (req_value >= ASCII_LA && req_value <= ASCII_LZ)
        begin
            upper = req_value - CASE_GAP;
        end
        key_letter = (upper >= ASCII_UA) && (upper <= ASCII_UZ);
        key_off    = upper - ASCII_UA;
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        place_idx  = fill_letter(cnt_reg);
        place_try  = 1'b0;
        inverse_wr = '0;
        walk_rd    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (action_t'(req_action))
                        ACT_CLEAR:
                        begin
                            used_next = '0;
                            len_next  = '0;
                        end
                        ACT_KEY:
                        begin
                            place_idx = key_off[IDX_W-1:0];
                            place_try = key_letter;
                        end
                        ACT_FINISH:
                        begin
                            state_next = ST_FILL;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                place_try = 1'b1;
                cnt_next  = cnt_reg + idx_t'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_INVERT;
                    cnt_next   = '0;
                end
            end
            ST_INVERT:
            begin
                // Read position cnt of the cipher table; in the next cycle the
                // letter found there is written back as an inverse entry.
                walk_rd.en   = (cnt_reg != idx_t'(ALPHABET));
                walk_rd.addr = walk_rd.en ? cnt_reg : '0;
                if (cnt_reg != '0)
                begin
                    inverse_wr.we   = 1'b1;
                    inverse_wr.addr = cipher_eff;
                    inverse_wr.data = cnt_reg - idx_t'(1);
                end
                cnt_next = cnt_reg + idx_t'(1);
                if (cnt_reg == idx_t'(ALPHABET))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        place_ok = place_try && (len_reg < idx_t'(ALPHABET)) && !used_reg[place_idx];
        cipher_wr.we   = place_ok;
        cipher_wr.addr = len_reg;
        cipher_wr.data = place_idx;
        if (place_ok)
        begin
            used_next[place_idx] = 1'b1;
            len_next             = len_reg + idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/keyword_substitution_cipher.sv
// Keyword substitution cipher, top level. Depends on kwsc_pkg, kwsc_if,
// kwsc_table_ram and kwsc_key_ctrl.
//
// Use: requests arrive on the req channel (valid/ready, action and value).
// A clear request empties the key, key-character requests add letters to the
// cipher alphabet, and a finish request completes the alphabet with the
// unused letters and rebuilds the decrypt table. Only data requests give a
// result, one out_byte on the res channel, in request order.
// The direction register selects the encrypt table (0) or the decrypt table
// (1); the user is to write it through cfg_we/cfg_data only while the block
// is idle, which the block itself does not enforce.
// Timing: data requests are taken one per cycle unless busy or stalled; a
// result passes from the registered read of the table RAM to the output
// register. Clear and key requests do not make the block busy. A finish
// request holds ready low through the fill walk, which places the unused
// letters in fill order, and the inverse build, which streams the cipher
// RAM through its single read port into the inverse RAM.
// When the receiver stalls, the result waits in the output register and one
// more data request may be held in the lookup stage; ready drops only once
// both are occupied. Reset clears the key, the direction and both channels;
// the tables then read as their empty-key contents.
module keyword_substitution_cipher
    import kwsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_data,
    kwsc_req_if.sink      req,
    kwsc_res_if.source    res
);

    logic direction_reg;

    // Lookup stage: a data request waiting for its table read.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_letter_reg;
    logic       s1_lower_reg;
    idx_t       s1_idx_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;

    logic       fire;
    logic       stall;
    logic       busy;
    logic       is_upper;
    logic       is_lower;
    logic [7:0] letter_off;
    idx_t       req_idx;
    idx_t       look_addr;

    ram_wr_t    cipher_wr;
    ram_wr_t    inverse_wr;
    walk_rd_t   walk_rd;
    idx_t       cipher_raddr;
    idx_t       c_rd_data, c_rd_addr, i_rd_data, i_rd_addr;
    logic       c_rd_valid, i_rd_valid;
    idx_t       cipher_eff;
    idx_t       inverse_eff;
    idx_t       lookup;
    logic [7:0] result;

    // Requests stall on busy, or when the lookup stage cannot move on.
    assign stall     = s1_valid_reg && out_valid_reg && !res.ready;
    assign req.ready = !busy && !stall;
    assign fire      = req.valid && req.ready;

    always_comb
    begin
        is_upper   = (req.value >= ASCII_UA) && (req.value <= ASCII_UZ);
        is_lower   = (req.value >= ASCII_LA) && (req.value <= ASCII_LZ);
        letter_off = req.value - (is_lower ? ASCII_LA : ASCII_UA);
        // Non-letters read entry zero so the RAM address stays in range.
        req_idx    = (is_upper || is_lower) ? letter_off[IDX_W-1:0] : '0;
        // While stalled, the held address is read again every cycle, so the
        // RAM output stays valid for the waiting request.
        look_addr    = stall ? s1_idx_reg : req_idx;
        cipher_raddr = walk_rd.en ? walk_rd.addr : look_addr;
    end

    kwsc_table_ram u_cipher_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (cipher_wr),
        .rd_addr   (cipher_raddr),
        .rd_data   (c_rd_data),
        .rd_valid  (c_rd_valid),
        .rd_addr_q (c_rd_addr)
    );

    kwsc_table_ram u_inverse_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (inverse_wr),
        .rd_addr   (look_addr),
        .rd_data   (i_rd_data),
        .rd_valid  (i_rd_valid),
        .rd_addr_q (i_rd_addr)
    );

    // Entries not yet written since reset hold the empty-key tables.
    assign cipher_eff  = c_rd_valid ? c_rd_data : fill_letter(c_rd_addr);
    assign inverse_eff = i_rd_valid ? i_rd_data : inverse_reset(i_rd_addr);

    kwsc_key_ctrl u_key_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_fire   (fire),
        .req_action (req.action),
        .req_value  (req.value),
        .cipher_eff (cipher_eff),
        .busy       (busy),
        .cipher_wr  (cipher_wr),
        .inverse_wr (inverse_wr),
        .walk_rd    (walk_rd)
    );

    always_comb
    begin
        lookup = direction_reg ? inverse_eff : cipher_eff;
        if (s1_letter_reg)
        begin
            result = (s1_lower_reg ? ASCII_LA : ASCII_UA) + {{(8 - IDX_W){1'b0}}, lookup};
        end
        else
        begin
            result = s1_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                direction_reg <= cfg_data;
            end
            if (!stall)
            begin
                s1_valid_reg <= fire && (action_t'(req.action) == ACT_DATA);
            end
            if (!out_valid_reg || res.ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_byte_reg   <= req.value;
            s1_letter_reg <= is_upper || is_lower;
            s1_lower_reg  <= is_lower;
            s1_idx_reg    <= req_idx;
        end
        if (s1_valid_reg && (!out_valid_reg || res.ready))
        begin
            out_byte_reg <= result;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_byte_reg;

endmodule

### rtl/kwsc_checker.sv
// Port-level checker for the keyword substitution cipher and the bind that
// attaches it to the top level. Depends on kwsc_pkg.
module kwsc_checker
    import kwsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_action,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_out_byte
);

    logic req_fire;
    logic key_fire;

    assign req_fire = req_valid && req_ready;
    assign key_fire = req_fire && (req_action != ACT_DATA);

    // A result that is not taken stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before it was taken");

    // A waiting result keeps its value.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_out_byte))
        else $error("waiting result changed");

    // A finish request makes the block busy in the following cycle.
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_action == ACT_FINISH) |=> !req_ready)
        else $error("request taken during the key finish walk");

    // Two non-data requests in a row with the result channel empty give no result.
    a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
        key_fire && $past(key_fire) && !res_valid |=> !res_valid)
        else $error("result produced by a key request");

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_action   (req.action),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_out_byte (res.out_byte)
);

### bench/keyword_substitution_cipher_tb.sv
// Self-checking bench for the keyword substitution cipher: a directed table of
// requests, then random clear/key/finish/data sequences checked against a predictor.
// Depends on kwsc_pkg, kwsc_if and the RTL top keyword_substitution_cipher.
module keyword_substitution_cipher_tb;
    import kwsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A finish request keeps the block busy through its fill walk and inverse
    // build; allow a margin before any register write and at the end of the run.
    localparam int SETTLE_CYCLES = 64;
    // Cycles without any accepted request or result before the run is abandoned.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 175;
    localparam int N_DIRECTED    = 26;

    // Order in which unused letters complete the cipher alphabet.
    localparam logic [8*ALPHABET-1:0] FILL_ORDER = "ZXYWVUTSRQPONMLKJIHGFEDCBA";

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    kwsc_req_if req_ch ();
    kwsc_res_if res_ch ();

    keyword_substitution_cipher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .res      (res_ch)
    );

    // One row of the directed table. Where typed is set, the expected
    // out_byte is given in the row; otherwise it comes from the predictor.
    typedef struct packed {
        logic       dir;
        action_t    act;
        logic [7:0] value;
        logic       typed;
        logic [7:0] out;
    } stim_row_t;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // Empty-key alphabet straight after reset: A->Z, Z->A, case kept.
        '{1'b0, ACT_DATA,   "A",   1'b1, "Z"},
        '{1'b0, ACT_DATA,   "a",   1'b1, "z"},
        '{1'b0, ACT_DATA,   "Z",   1'b1, "A"},
        // Bytes outside the letters, at the range ends and beside each letter run.
        '{1'b0, ACT_DATA,   8'h00, 1'b1, 8'h00},
        '{1'b0, ACT_DATA,   8'hFF, 1'b1, 8'hFF},
        '{1'b0, ACT_DATA,   "@",   1'b1, "@"},
        '{1'b0, ACT_DATA,   "[",   1'b1, "["},
        '{1'b0, ACT_DATA,   8'h60, 1'b1, 8'h60},
        '{1'b0, ACT_DATA,   "{",   1'b1, "{"},
        // Key entry: lower case folded, a repeat and non-letters ignored.
        '{1'b0, ACT_KEY,    "k",   1'b0, 8'h00},
        '{1'b0, ACT_KEY,    "E",   1'b0, 8'h00},
        '{1'b0, ACT_KEY,    "K",   1'b0, 8'h00},
        '{1'b0, ACT_KEY,    "3",   1'b0, 8'h00},
        '{1'b0, ACT_KEY,    8'hFF, 1'b0, 8'h00},
        // Data while the key is only partly entered.
        '{1'b0, ACT_DATA,   "a",   1'b0, 8'h00},
        '{1'b0, ACT_DATA,   "C",   1'b0, 8'h00},
        '{1'b0, ACT_FINISH, 8'h00, 1'b0, 8'h00},
        // A key letter after finish is ignored; a second finish changes nothing.
        '{1'b0, ACT_KEY,    "Q",   1'b0, 8'h00},
        '{1'b0, ACT_FINISH, 8'hFF, 1'b0, 8'h00},
        '{1'b0, ACT_DATA,   "b",   1'b0, 8'h00},
        // Decrypt, then a clear that leaves both tables as they stand.
        '{1'b1, ACT_DATA,   "K",   1'b0, 8'h00},
        '{1'b1, ACT_DATA,   "z",   1'b0, 8'h00},
        '{1'b1, ACT_CLEAR,  8'hFF, 1'b0, 8'h00},
        '{1'b1, ACT_KEY,    "z",   1'b0, 8'h00},
        '{1'b1, ACT_DATA,   "A",   1'b0, 8'h00},
        '{1'b1, ACT_FINISH, 8'h00, 1'b0, 8'h00}
    };

    // Predictor state, kept apart from the block.
    idx_t          cipher_tbl  [ALPHABET];
    idx_t          inverse_tbl [ALPHABET];
    logic [25:0]   letters_used;
    logic [4:0]    key_len;
    logic          decrypt_mode;

    // Output bytes still owed by the block, oldest first.
    logic [7:0]    expected_bytes [$];

    int            error_count;
    int            idle_cycles;
    int            items_sent;
    bit            gaps_on;

    function automatic void place_letter(input idx_t letter);
        if (letter >= ALPHABET || key_len >= ALPHABET)
            return;
        if (letters_used[letter])
            return;
        letters_used[letter] = 1'b1;
        cipher_tbl[key_len]  = letter;
        key_len++;
    endfunction

    // Fill the rest of the alphabet in fill order, then rebuild the inverse.
    function automatic void complete_alphabet();
        for (int i = 0; i < ALPHABET; i++)
            place_letter(idx_t'(FILL_ORDER[8*(ALPHABET-1-i) +: 8] - ASCII_UA));
        for (int i = 0; i < ALPHABET; i++)
            inverse_tbl[cipher_tbl[i] % ALPHABET] = idx_t'(i);
    endfunction

    function automatic void reset_cipher_model();
        decrypt_mode = 1'b0;
        letters_used = '0;
        key_len      = '0;
        complete_alphabet();
        letters_used = '0;
        key_len      = '0;
    endfunction

    // Apply one request to the predictor; returns 1 when it yields a result.
    function automatic bit predict_cipher(input action_t act, input logic [7:0] v,
                                          output logic [7:0] sub_byte);
        logic [7:0] upper;
        idx_t       mapped;
        sub_byte = v;
        case (act)
            ACT_CLEAR:
            begin
                letters_used = '0;
                key_len      = '0;
                return 1'b0;
            end
            ACT_KEY:
            begin
                upper = (v >= ASCII_LA && v <= ASCII_LZ) ? v - CASE_GAP : v;
                if (upper >= ASCII_UA && upper <= ASCII_UZ)
                    place_letter(idx_t'(upper - ASCII_UA));
                return 1'b0;
            end
            ACT_FINISH:
            begin
                complete_alphabet();
                return 1'b0;
            end
            default:
            begin
                if (v >= ASCII_UA && v <= ASCII_UZ)
                begin
                    mapped   = decrypt_mode ? inverse_tbl[v - ASCII_UA]
                                            : cipher_tbl[v - ASCII_UA];
                    sub_byte = ASCII_UA + 8'(mapped);
                end
                else if (v >= ASCII_LA && v <= ASCII_LZ)
                begin
                    mapped   = decrypt_mode ? inverse_tbl[v - ASCII_LA]
                                            : cipher_tbl[v - ASCII_LA];
                    sub_byte = ASCII_LA + 8'(mapped);
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: stalls on about a third of cycles unless gaps are switched off.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 33);
        end
    end

    // Every accepted result is matched against the oldest expected byte.
    // Signals are sampled as they stood just before the edge.
    initial
    begin
        logic [7:0] want;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %02h",
                             $time, res_ch.out_byte);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (res_ch.out_byte !== want)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want, res_ch.out_byte);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: abandon the run if neither channel moves for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one request, with random idle cycles in front of it, and hold it
    // until the block takes it. Called at a clock edge; returns at the edge of
    // acceptance without touching valid, so the caller decides what follows.
    task automatic send_request(input action_t act, input logic [7:0] v,
                                input logic typed, input logic [7:0] typed_out);
        logic [7:0] sub_byte;
        bit         has_result;
        while (gaps_on && $urandom_range(0, 99) < 33)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        has_result = predict_cipher(act, v, sub_byte);
        if (has_result)
            expected_bytes.push_back(typed ? typed_out : sub_byte);
        items_sent++;
    endtask

    // Stop sending and wait until every result is in and any finish walk is over.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic set_direction(input logic dir);
        drain_block();
        cfg_we   <= 1'b1;
        cfg_data <= dir;
        @(posedge clk);
        cfg_we   <= 1'b0;
        decrypt_mode = dir;
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? ASCII_LA : ASCII_UA;
        return base + 8'($urandom_range(0, ALPHABET - 1));
    endfunction

    // Mostly well-formed key sequences followed by data bursts; the rest is
    // noise and sequences that never reach their finish.
    task automatic run_random_phase(input int budget);
        int         stop_at;
        int         n;
        logic [7:0] v;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                send_request(ACT_CLEAR, 8'($urandom), 1'b0, 8'h00);
                n = $urandom_range(0, 30);
                for (int i = 0; i < n; i++)
                begin
                    v = ($urandom_range(0, 99) < 90) ? random_letter() : 8'($urandom);
                    send_request(ACT_KEY, v, 1'b0, 8'h00);
                end
                if ($urandom_range(0, 99) < 95)
                    send_request(ACT_FINISH, 8'($urandom), 1'b0, 8'h00);
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++)
                begin
                    v = ($urandom_range(0, 99) < 85) ? random_letter() : 8'($urandom);
                    send_request(ACT_DATA, v, 1'b0, 8'h00);
                end
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_request(action_t'($urandom_range(0, 3)), 8'($urandom),
                                 1'b0, 8'h00);
            end
        end
    endtask

    // Main sequence: reset, directed table, four random phases that alternate
    // the direction, with one of them run without any idling on either side.
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_CLEAR;
        req_ch.value  <= 8'h00;
        error_count = 0;
        items_sent  = 0;
        gaps_on     = 1'b1;
        reset_cipher_model();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_direction(1'b0);
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            if (directed_rows[r].dir !== decrypt_mode)
                set_direction(directed_rows[r].dir);
            send_request(directed_rows[r].act, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].out);
        end

        for (int p = 0; p < 4; p++)
        begin
            // Each register write here also leaves the sender paused until
            // every outstanding result has come back.
            set_direction(p[0]);
            gaps_on = (p != 2);
            run_random_phase(PHASE_ITEMS);
        end
        gaps_on = 1'b1;

        drain_block();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
